FILE: hdl/lcdst_pkg.sv
// ----------------------------------------------------------------------------
// lcdst_pkg
// Types and constants shared by the LCD scanline timing controller.
// ----------------------------------------------------------------------------
package lcdst_pkg;

  localparam int DOT_W     = 9;
  localparam int LINE_W    = 8;
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int IRQ_EN_W  = 4;

  localparam int DOTS_PER_LINE_DEF = 456;
  localparam int VISIBLE_LINES_DEF = 144;
  localparam int LAST_LINE_DEF     = 153;
  localparam int SCAN_DOTS_DEF     = 80;
  localparam int LINE_PIXELS_DEF   = 160;

  typedef enum logic [1:0] {
    MODE_LINE_GAP  = 2'd0,
    MODE_FRAME_GAP = 2'd1,
    MODE_SCAN      = 2'd2,
    MODE_PIXELS    = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_LCD_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_LINE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IRQ_ENABLES  = 2'd2;

  localparam int IRQ_BIT_HBLANK  = 0;
  localparam int IRQ_BIT_VBLANK  = 1;
  localparam int IRQ_BIT_SCAN    = 2;
  localparam int IRQ_BIT_COMPARE = 3;

endpackage

FILE: hdl/lcd_scanline_timing.sv
// ----------------------------------------------------------------------------
// lcd_scanline_timing
// Dot, line and mode timing of an LCD controller with STAT, vblank and
// frame pulses. One dot tick per input transfer that has advance set.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready    advance
//   out      output     out_valid / out_ready  mode line dot coincidence
//                                              stat_irq vblank_irq frame_done
//                                              pixel_valid pixel_x
//   cfg      input      cfg_write              cfg_index cfg_data
//
// One tick per cycle while in_ready is high.
// The timing state and the result register are updated together at the
// input transfer, so the path is one increment, a few compares and muxes.
// in_ready is high whenever the result register is empty or being taken.
// Reset clears the counters, flags, configuration and out_valid.
// ----------------------------------------------------------------------------
module lcd_scanline_timing #(
  parameter int DOTS_PER_LINE = lcdst_pkg::DOTS_PER_LINE_DEF,
  parameter int VISIBLE_LINES = lcdst_pkg::VISIBLE_LINES_DEF,
  parameter int LAST_LINE     = lcdst_pkg::LAST_LINE_DEF,
  parameter int SCAN_DOTS     = lcdst_pkg::SCAN_DOTS_DEF,
  parameter int LINE_PIXELS   = lcdst_pkg::LINE_PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lcdst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcdst_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            advance,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      mode,
  output logic [lcdst_pkg::LINE_W-1:0]    line,
  output logic [lcdst_pkg::DOT_W-1:0]     dot,
  output logic                            coincidence,
  output logic                            stat_irq,
  output logic                            vblank_irq,
  output logic                            frame_done,
  output logic                            pixel_valid,
  output logic [lcdst_pkg::PIX_W-1:0]     pixel_x
);
  import lcdst_pkg::*;

  localparam logic [DOT_W-1:0]  DPL_C  = DOT_W'(DOTS_PER_LINE);
  localparam logic [DOT_W-1:0]  SCAN_C = DOT_W'(SCAN_DOTS);
  localparam logic [LINE_W:0]   VIS_C  = (LINE_W+1)'(VISIBLE_LINES);
  localparam logic [LINE_W:0]   LAST_C = (LINE_W+1)'(LAST_LINE);
  localparam logic [PIX_W-1:0]  PIX_C  = PIX_W'(LINE_PIXELS);

  // configuration
  logic                lcd_enable;
  logic [LINE_W-1:0]   compare_line;
  logic [IRQ_EN_W-1:0] irq_enables;

  // timing state
  logic [DOT_W-1:0]  dot_counter, dot_counter_next;
  logic [LINE_W-1:0] line_counter, line_counter_next;
  logic [PIX_W-1:0]  pixel_counter, pixel_counter_next;
  mode_t             mode_reg, mode_reg_next;
  logic              coincidence_flag, coincidence_flag_next;
  logic              cleared_flag, cleared_flag_next;

  logic              stat_next, vbl_next, frame_next, pvalid_next;
  logic [PIX_W-1:0]  px_next;
  logic [DOT_W-1:0]  dot_inc;
  logic [LINE_W:0]   line_inc;
  mode_t             mode_sel;
  logic              in_xfer;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_enable   <= 1'b0;
      compare_line <= '0;
      irq_enables  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LCD_ENABLE:   lcd_enable   <= cfg_data[0];
        REG_COMPARE_LINE: compare_line <= cfg_data[LINE_W-1:0];
        REG_IRQ_ENABLES:  irq_enables  <= cfg_data[IRQ_EN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dot_counter_next      = dot_counter;
    line_counter_next     = line_counter;
    pixel_counter_next    = pixel_counter;
    mode_reg_next         = mode_reg;
    coincidence_flag_next = coincidence_flag;
    cleared_flag_next     = cleared_flag;
    stat_next             = 1'b0;
    vbl_next              = 1'b0;
    frame_next            = 1'b0;
    pvalid_next           = 1'b0;
    px_next               = '0;
    dot_inc               = dot_counter + DOT_W'(1);
    line_inc              = {1'b0, line_counter} + (LINE_W+1)'(1);
    mode_sel              = MODE_LINE_GAP;

    if (!lcd_enable) begin
      dot_counter_next   = '0;
      line_counter_next  = '0;
      pixel_counter_next = '0;
      mode_reg_next      = MODE_LINE_GAP;
      if (!cleared_flag) begin
        cleared_flag_next = 1'b1;
        frame_next        = 1'b1;
      end
    end else begin
      cleared_flag_next = 1'b0;
      if (advance) begin
        dot_counter_next = dot_inc;
        if ({1'b0, line_counter} >= VIS_C) begin
          mode_sel = MODE_FRAME_GAP;
        end else if (dot_inc <= SCAN_C) begin
          mode_sel = MODE_SCAN;
        end else if (pixel_counter < PIX_C) begin
          mode_sel           = MODE_PIXELS;
          pvalid_next        = 1'b1;
          px_next            = pixel_counter;
          pixel_counter_next = pixel_counter + PIX_W'(1);
        end else begin
          mode_sel = MODE_LINE_GAP;
        end

        if (mode_sel != mode_reg) begin
          mode_reg_next = mode_sel;
          case (mode_sel)
            MODE_LINE_GAP:  stat_next = irq_enables[IRQ_BIT_HBLANK];
            MODE_FRAME_GAP: stat_next = irq_enables[IRQ_BIT_VBLANK];
            MODE_SCAN:      stat_next = irq_enables[IRQ_BIT_SCAN];
            default:        stat_next = 1'b0;
          endcase
        end

        // line end
        if (dot_inc == DPL_C) begin
          dot_counter_next   = '0;
          pixel_counter_next = '0;
          if (line_inc == VIS_C) begin
            vbl_next   = 1'b1;
            frame_next = 1'b1;
          end
          line_counter_next = (line_inc > LAST_C) ? '0 : line_inc[LINE_W-1:0];
          if (line_counter_next == compare_line) begin
            coincidence_flag_next = 1'b1;
            if (irq_enables[IRQ_BIT_COMPARE]) begin
              stat_next = 1'b1;
            end
          end else begin
            coincidence_flag_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_counter      <= '0;
      line_counter     <= '0;
      pixel_counter    <= '0;
      mode_reg         <= MODE_LINE_GAP;
      coincidence_flag <= 1'b0;
      cleared_flag     <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (in_xfer) begin
        dot_counter      <= dot_counter_next;
        line_counter     <= line_counter_next;
        pixel_counter    <= pixel_counter_next;
        mode_reg         <= mode_reg_next;
        coincidence_flag <= coincidence_flag_next;
        cleared_flag     <= cleared_flag_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode        <= mode_reg_next;
      line        <= line_counter_next;
      dot         <= dot_counter_next;
      coincidence <= coincidence_flag_next;
      stat_irq    <= stat_next;
      vblank_irq  <= vbl_next;
      frame_done  <= frame_next;
      pixel_valid <= pvalid_next;
      pixel_x     <= px_next;
    end
  end

`ifndef ASSERT_OFF
  a_xfer_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> out_valid)
    else $error("input transfer did not produce a result");

  a_pixel_in_draw: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pixel_valid) |-> (mode == MODE_PIXELS))
    else $error("pixel slot outside draw mode");

  a_vblank_at_line_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && vblank_irq) |-> (frame_done && dot == '0))
    else $error("vblank pulse not at line end with frame pulse");

  a_dot_in_range: assert property (@(posedge clk) disable iff (rst)
    dot_counter < DPL_C)
    else $error("dot counter past line length");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_scanline_timing testbench
// Drives dot ticks into the scanline timing controller with random gaps on
// the tick input and random stalls on the status output. A per-transfer
// model of the dot, line and mode counters predicts every status transfer,
// and each one is compared field by field. Tests cover the disabled state,
// start-up, one full line into a line compare, and random register
// settings.
// ----------------------------------------------------------------------------
module testbench;
  import lcdst_pkg::*;

  localparam int DOTS_PER_LINE = DOTS_PER_LINE_DEF;
  localparam int VISIBLE_LINES = VISIBLE_LINES_DEF;
  localparam int LAST_LINE     = LAST_LINE_DEF;
  localparam int SCAN_DOTS     = SCAN_DOTS_DEF;
  localparam int LINE_PIXELS   = LINE_PIXELS_DEF;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int REPORT_LIMIT = 100;

  typedef struct packed {
    mode_t             mode;
    logic [LINE_W-1:0] line;
    logic [DOT_W-1:0]  dot;
    logic              coincidence;
    logic              stat_irq;
    logic              vblank_irq;
    logic              frame_done;
    logic              pixel_valid;
    logic [PIX_W-1:0]  pixel_x;
  } scan_status_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 advance;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           mode;
  logic [LINE_W-1:0]    line;
  logic [DOT_W-1:0]     dot;
  logic                 coincidence;
  logic                 stat_irq;
  logic                 vblank_irq;
  logic                 frame_done;
  logic                 pixel_valid;
  logic [PIX_W-1:0]     pixel_x;

  // timing model state and its copy of the registers
  logic              lcd_on;
  logic [LINE_W-1:0] cmp_line;
  logic [3:0]        irq_en;
  logic [DOT_W-1:0]  t_dot;
  logic [LINE_W-1:0] t_line;
  logic [PIX_W-1:0]  t_pix;
  mode_t             t_mode;
  logic              t_coin;
  logic              t_cleared;

  scan_status_t pending_status[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           tx_gap_on;
  bit           rx_stall_on;

  lcd_scanline_timing #(
    .DOTS_PER_LINE (DOTS_PER_LINE),
    .VISIBLE_LINES (VISIBLE_LINES),
    .LAST_LINE     (LAST_LINE),
    .SCAN_DOTS     (SCAN_DOTS),
    .LINE_PIXELS   (LINE_PIXELS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mode        (mode),
    .line        (line),
    .dot         (dot),
    .coincidence (coincidence),
    .stat_irq    (stat_irq),
    .vblank_irq  (vblank_irq),
    .frame_done  (frame_done),
    .pixel_valid (pixel_valid),
    .pixel_x     (pixel_x)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic scan_status_t next_scan_status(input logic adv);
    scan_status_t r;
    mode_t        nxt;
    int           nl;
    r = '0;
    if (!lcd_on) begin
      t_dot  = '0;
      t_pix  = '0;
      t_line = '0;
      t_mode = MODE_LINE_GAP;
      if (!t_cleared) begin
        t_cleared    = 1'b1;
        r.frame_done = 1'b1;
      end
    end else begin
      t_cleared = 1'b0;
      if (adv) begin
        t_dot = t_dot + 1'b1;
        if (t_line >= VISIBLE_LINES) begin
          nxt = MODE_FRAME_GAP;
        end else if (t_dot <= SCAN_DOTS) begin
          nxt = MODE_SCAN;
        end else if (t_pix < LINE_PIXELS) begin
          nxt           = MODE_PIXELS;
          r.pixel_valid = 1'b1;
          r.pixel_x     = t_pix;
          t_pix         = t_pix + 1'b1;
        end else begin
          nxt = MODE_LINE_GAP;
        end
        if (nxt != t_mode) begin
          t_mode = nxt;
          if (nxt == MODE_LINE_GAP)  r.stat_irq = irq_en[IRQ_BIT_HBLANK];
          if (nxt == MODE_FRAME_GAP) r.stat_irq = irq_en[IRQ_BIT_VBLANK];
          if (nxt == MODE_SCAN)      r.stat_irq = irq_en[IRQ_BIT_SCAN];
        end
        if (t_dot == DOTS_PER_LINE) begin
          nl    = int'(t_line) + 1;
          t_dot = '0;
          t_pix = '0;
          if (nl == VISIBLE_LINES) begin
            r.vblank_irq = 1'b1;
            r.frame_done = 1'b1;
          end
          if (nl > LAST_LINE) nl = 0;
          t_line = nl[LINE_W-1:0];
          t_coin = (t_line == cmp_line);
          if (t_coin && irq_en[IRQ_BIT_COMPARE]) r.stat_irq = 1'b1;
        end
      end
    end
    r.mode        = t_mode;
    r.line        = t_line;
    r.dot         = t_dot;
    r.coincidence = t_coin;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // status output: compare every transfer against the oldest prediction
  always @(posedge clk) begin
    scan_status_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        report_mismatch($sformatf("status transfer with nothing expected, line %0d dot %0d",
                                  line, dot));
      end else begin
        want = pending_status.pop_front();
        check_field("mode", mode, want.mode);
        check_field("line", line, want.line);
        check_field("dot", dot, want.dot);
        check_field("coincidence", coincidence, want.coincidence);
        check_field("stat_irq", stat_irq, want.stat_irq);
        check_field("vblank_irq", vblank_irq, want.vblank_irq);
        check_field("frame_done", frame_done, want.frame_done);
        check_field("pixel_valid", pixel_valid, want.pixel_valid);
        check_field("pixel_x", pixel_x, want.pixel_x);
      end
    end
  end

  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rx_stall_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_tick(input logic adv);
    int           gap;
    scan_status_t want;
    gap = tx_gap_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    advance  <= adv;
    want = next_scan_status(adv);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_status.push_back(want);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_LCD_ENABLE:   lcd_on   = data[0];
      REG_COMPARE_LINE: cmp_line = data;
      REG_IRQ_ENABLES:  irq_en   = data[3:0];
      default: ;
    endcase
  endtask

  // display off after reset: counters read zero, one frame pulse
  task automatic test_disabled();
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_start_up();
    wait_idle();
    write_reg(REG_COMPARE_LINE, 8'h00);
    write_reg(REG_IRQ_ENABLES, 8'hFF);
    write_reg(REG_LCD_ENABLE, 8'h01);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    wait_idle();
    write_reg(REG_LCD_ENABLE, 8'hFE);
    send_tick(1'b1);
    send_tick(1'b1);
    wait_idle();
    write_reg(REG_LCD_ENABLE, 8'h01);
    send_tick(1'b1);
  endtask

  // one line through scan, draw and hblank into a matching line compare
  task automatic test_line_sweep();
    logic [LINE_W-1:0] start_line;
    wait_idle();
    write_reg(REG_COMPARE_LINE, t_line + 8'd1);
    write_reg(REG_IRQ_ENABLES, 8'h09);
    start_line = t_line;
    while (t_line == start_line) send_tick(1'b1);
    repeat (4) send_tick(1'b1);
    // off with the compare flag set: flag must hold
    wait_idle();
    write_reg(REG_LCD_ENABLE, 8'h00);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_idle();
    write_reg(REG_LCD_ENABLE, 8'h01);
  endtask

  task automatic test_random();
    logic [CFG_W-1:0] en_data;
    logic [CFG_W-1:0] cmp;
    logic [CFG_W-1:0] irq;
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      tx_gap_on   = $urandom_range(0, 3) != 0;
      rx_stall_on = $urandom_range(0, 3) != 0;
      en_data    = 8'($urandom);
      en_data[0] = $urandom_range(0, 7) != 0;
      case ($urandom_range(0, 3))
        0:       cmp = t_line + 8'd1;
        1:       cmp = 8'h00;
        2:       cmp = 8'hFF;
        default: cmp = 8'($urandom);
      endcase
      if (phase == 0)      irq = 8'h0F;
      else if (phase == 1) irq = 8'hF0;
      else                 irq = 8'($urandom);
      write_reg(REG_LCD_ENABLE, en_data);
      write_reg(REG_COMPARE_LINE, cmp);
      write_reg(REG_IRQ_ENABLES, irq);
      if (phase == 4) write_reg(REG_UNUSED, 8'($urandom));
      for (int i = 0; i < 6; i++) begin
        if (phase == 3 && i == 3) wait_idle();
        send_tick($urandom_range(0, 7) != 0);
      end
    end
  endtask

  initial begin
    lcd_on      = 1'b0;
    cmp_line    = '0;
    irq_en      = '0;
    t_dot       = '0;
    t_line      = '0;
    t_pix       = '0;
    t_mode      = MODE_LINE_GAP;
    t_coin      = 1'b0;
    t_cleared   = 1'b0;
    tx_gap_on   = 1'b1;
    rx_stall_on = 1'b1;
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_LCD_ENABLE;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    advance   <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_disabled();
    test_start_up();
    test_line_sweep();
    test_random();

    wait_idle();
    repeat (5) @(posedge clk);
    if (pending_status.size() != 0)
      report_mismatch($sformatf("%0d status transfers never arrived", pending_status.size()));
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
